[hdl/rau_pkg.sv]
// Package with shared types and constants of the rational arithmetic unit.
package rau_pkg;
    localparam int CMD_W = 4;
    localparam int NUM_W = 32;
    localparam int DEN_W = 31;
    localparam int ST_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
        CMD_EQ  = 4'd4, CMD_GT  = 4'd5, CMD_LT  = 4'd6, CMD_INC = 4'd7,
        CMD_DEC = 4'd8
    } t_cmd;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_DIVZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [ST_W-1:0] ST_ZERODEN = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [NUM_W-1:0] a_num;
        logic [DEN_W-1:0] a_den;
        logic [NUM_W-1:0] b_num;
        logic [DEN_W-1:0] b_den;
    } t_in;

    typedef struct packed {
        logic [NUM_W-1:0] res_num;
        logic [DEN_W-1:0] res_den;
        logic             compare_true;
        logic [ST_W-1:0]  status;
    } t_out;
endpackage

[hdl/rau_if.sv]
// Valid-ready channel interfaces for the rational arithmetic unit.
interface rau_in_if import rau_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rau_out_if import rau_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/rau_divider.sv]
// Restoring 64-bit unsigned divider that produces one quotient bit per cycle.
module rau_divider import rau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);
    logic [63:0] r_q;
    logic [63:0] r_r;
    logic [63:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_sh;
    logic [64:0] w_sub;

    assign w_sh  = {r_r, r_q[63]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                if (w_sub[64]) begin
                    r_r <= w_sh[63:0];
                    r_q <= {r_q[62:0], 1'b0};
                end else begin
                    r_r <= w_sub[63:0];
                    r_q <= {r_q[62:0], 1'b1};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

[hdl/rational_arithmetic_unit.sv]
// Rational arithmetic unit top level with sequencer, shared divider and multiplier.
// Fraction results run the serial 64-bit divider once per Euclid step and twice for the
// reduction; an add or subtract runs it twice more for the lcm scale factors.
// One transaction at a time; the input is not ready while one is in work
// or while a finished result waits unaccepted. Reset: synchronous, active low.
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_PREP, S_GCD_START, S_GCD_WAIT,
        S_DIVN_START, S_DIVN_WAIT, S_DIVD_START, S_DIVD_WAIT, S_FIN, S_LCM
    } t_state;

    localparam logic signed [63:0] MAX_V = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] MIN_V = -MAX_V - 64'sd1;

    t_state r_state;
    t_in    r_in;
    logic signed [63:0] r_p0, r_p1, r_num, r_den, r_n, r_d, r_g, r_l;
    logic [63:0] r_gx, r_gy;
    logic [1:0]  r_gmode;
    logic [1:0]  r_ph;
    logic        r_busy;
    logic        r_oval;
    t_out        r_out;

    logic        w_dstart;
    logic [63:0] w_dvd, w_dvs, w_quot, w_rem;
    logic        w_ddone;
    logic signed [32:0] w_ma, w_mb;
    logic signed [63:0] w_prod;

    rau_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_dividend(w_dvd), .i_divisor(w_dvs),
        .o_done(w_ddone), .o_quot(w_quot), .o_rem(w_rem)
    );

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        f_mag = v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic f_rng(input logic signed [63:0] v);
        f_rng = (v >= MIN_V) && (v <= MAX_V);
    endfunction

    assign w_prod = 64'(w_ma * w_mb);

    always_comb begin
        w_ma = 33'(signed'(r_in.a_num));
        w_mb = 33'(signed'(r_in.b_num));
        unique case (t_cmd'(r_in.command))
            CMD_ADD, CMD_SUB: begin
                if (r_ph == 2'd0) begin
                    w_ma = 33'(signed'(r_in.a_num));
                    w_mb = 33'(r_p0);
                end else if (r_ph == 2'd1) begin
                    w_ma = 33'(signed'(r_in.b_num));
                    w_mb = 33'(r_p1);
                end else begin
                    w_ma = 33'(r_g);
                    w_mb = 33'(signed'({1'b0, r_in.b_den}));
                end
            end
            CMD_MUL: begin
                w_ma = (r_ph == 2'd0) ? 33'(signed'(r_in.a_num))
                                      : 33'(signed'({1'b0, r_in.a_den}));
                w_mb = (r_ph == 2'd0) ? 33'(signed'(r_in.b_num))
                                      : 33'(signed'({1'b0, r_in.b_den}));
            end
            CMD_DIV, CMD_EQ, CMD_GT, CMD_LT: begin
                w_ma = (r_ph == 2'd0) ? 33'(signed'(r_in.a_num))
                                      : 33'(signed'({1'b0, r_in.a_den}));
                w_mb = (r_ph == 2'd0) ? 33'(signed'({1'b0, r_in.b_den}))
                                      : 33'(signed'(r_in.b_num));
            end
            default: begin
                w_ma = 33'(r_g);
                w_mb = 33'(signed'({1'b0, r_in.b_den}));
            end
        endcase
    end

    always_comb begin
        w_dstart = 1'b0;
        w_dvd    = r_gx;
        w_dvs    = r_gy;
        unique case (r_state)
            S_GCD_START: w_dstart = 1'b1;
            S_DIVN_START: begin
                w_dstart = 1'b1;
                w_dvd    = f_mag(r_n);
                w_dvs    = r_gx;
            end
            S_DIVD_START: begin
                w_dstart = 1'b1;
                w_dvd    = f_mag(r_d);
                w_dvs    = r_gx;
            end
            default: ;
        endcase
    end

    assign i_in.ready  = !r_busy && !(r_oval && !o_out.ready);
    assign o_out.valid = r_oval;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            if (r_oval && o_out.ready && r_state != S_FIN) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_in    <= i_in.data;
                        r_out   <= '0;
                        r_busy  <= 1'b1;
                        r_ph    <= 2'd0;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_in.command <= CMD_LT && (r_in.a_den == '0 || r_in.b_den == '0)) begin
                        r_out.status <= ST_ZERODEN;
                        r_state      <= S_FIN;
                    end else if ((r_in.command == CMD_INC || r_in.command == CMD_DEC)
                                 && r_in.a_den == '0) begin
                        r_out.status <= ST_ZERODEN;
                        r_state      <= S_FIN;
                    end else if (r_in.command == CMD_ADD || r_in.command == CMD_SUB) begin
                        r_gx    <= 64'(r_in.a_den);
                        r_gy    <= 64'(r_in.b_den);
                        r_gmode <= 2'd1;
                        r_ph    <= 2'd2;
                        r_state <= S_GCD_START;
                    end else if (r_in.command >= CMD_MUL && r_in.command <= CMD_LT) begin
                        r_state <= S_MUL1;
                    end else if (r_in.command == CMD_INC || r_in.command == CMD_DEC) begin
                        r_n <= (r_in.command == CMD_INC)
                            ? 64'(signed'(r_in.a_num)) + 64'(signed'({1'b0, r_in.a_den}))
                            : 64'(signed'(r_in.a_num)) - 64'(signed'({1'b0, r_in.a_den}));
                        r_d     <= 64'(signed'({1'b0, r_in.a_den}));
                        r_state <= S_LCM;
                        r_ph    <= 2'd3;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_MUL1: begin
                    r_p0    <= w_prod;
                    r_ph    <= 2'd1;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p1 <= w_prod;
                    if (r_in.command == CMD_ADD || r_in.command == CMD_SUB) begin
                        r_n <= (r_in.command == CMD_ADD) ? r_p0 + w_prod : r_p0 - w_prod;
                        r_d <= r_l;
                        r_state <= S_LCM;
                        r_ph <= 2'd3;
                    end else if (r_in.command == CMD_EQ) begin
                        r_out.compare_true <= (r_p0 == w_prod);
                        r_state <= S_FIN;
                    end else if (r_in.command == CMD_GT) begin
                        r_out.compare_true <= (r_p0 > w_prod);
                        r_state <= S_FIN;
                    end else if (r_in.command == CMD_LT) begin
                        r_out.compare_true <= (r_p0 < w_prod);
                        r_state <= S_FIN;
                    end else if (r_in.command == CMD_DIV && r_in.b_num == '0) begin
                        r_out.status <= ST_DIVZERO;
                        r_state <= S_FIN;
                    end else if (!f_rng(r_p0) || !f_rng(w_prod)) begin
                        r_out.status <= ST_OVERFLOW;
                        r_state <= S_FIN;
                    end else begin
                        r_n <= r_p0;
                        r_d <= w_prod;
                        r_state <= S_LCM;
                        r_ph <= 2'd3;
                    end
                end
                S_LCM: begin
                    // Set up the gcd of the final numerator and denominator.
                    r_gx    <= f_mag(r_n);
                    r_gy    <= f_mag(r_d);
                    r_gmode <= 2'd2;
                    r_state <= S_GCD_START;
                end
                S_GCD_START: begin
                    if (r_gy == '0) begin
                        if (r_gmode == 2'd1) begin
                            // Denominator gcd found: form lcm = (a_den / g) * b_den.
                            r_g     <= signed'(r_gx);
                            r_gy    <= 64'(r_in.a_den);
                            r_gmode <= 2'd3;
                            r_state <= S_DIVD_START;
                            r_d     <= 64'(signed'({1'b0, r_in.a_den}));
                        end else begin
                            r_state <= S_DIVN_START;
                        end
                    end else begin
                        r_state <= S_GCD_WAIT;
                    end
                end
                S_GCD_WAIT: begin
                    if (w_ddone) begin
                        r_gx    <= r_gy;
                        r_gy    <= w_rem;
                        r_state <= S_GCD_START;
                    end
                end
                S_DIVN_START: r_state <= S_DIVN_WAIT;
                S_DIVN_WAIT: begin
                    if (w_ddone) begin
                        r_n     <= (r_n[63] ^ r_d[63]) ? -signed'(w_quot) : signed'(w_quot);
                        r_state <= S_DIVD_START;
                    end
                end
                S_DIVD_START: r_state <= S_DIVD_WAIT;
                S_DIVD_WAIT: begin
                    if (w_ddone) begin
                        if (r_gmode == 2'd3) begin
                            // r_g = a_den / gcd, then lcm and scale factors.
                            r_g <= signed'(w_quot);
                            r_gmode <= 2'd0;
                            r_state <= S_DIVD_START;
                            r_d <= 64'(signed'({1'b0, r_in.b_den}));
                            r_p1 <= signed'(w_quot);
                        end else if (r_gmode == 2'd0) begin
                            r_p0 <= signed'(w_quot);
                            r_l  <= w_prod;
                            r_ph <= 2'd0;
                            r_state <= S_MUL1;
                            r_gmode <= 2'd1;
                        end else begin
                            if (!f_rng(r_n) || signed'(w_quot) > MAX_V) begin
                                r_out.status <= ST_OVERFLOW;
                                r_out.res_num <= '0;
                                r_out.res_den <= '0;
                            end else begin
                                r_out.res_num <= r_n[NUM_W-1:0];
                                r_out.res_den <= w_quot[DEN_W-1:0];
                            end
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_oval || o_out.ready) begin
                        r_oval  <= 1'b1;
                        r_busy  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[dv/rau_checker.sv]
// Checker that predicts every rational unit result and compares it with the output channel.
module rau_checker import rau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_in_if    i_in,
    rau_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    localparam longint MAX_VAL = (64'sd1 <<< 31) - 1;

    t_out expected_results[$];

    function automatic bit fits_word(longint v);
        return v >= -MAX_VAL - 1 && v <= MAX_VAL;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
    endfunction

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduces num/den, makes the denominator positive and checks the word range.
    function automatic logic [ST_W-1:0] reduce_fraction(longint num, longint den,
                                                        output longint rn, output longint rd);
        longint g;
        g = longint'(gcd64(magnitude(num), magnitude(den)));
        num = num / g;
        den = den / g;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        rn = 0;
        rd = 0;
        if (!fits_word(num) || den > MAX_VAL) begin
            return ST_OVERFLOW;
        end
        rn = num;
        rd = den;
        return ST_OK;
    endfunction

    function automatic t_out predict_rational(t_in x);
        t_out r;
        longint an, ad, bn, bd, rn, rd, g, l, n, d;
        logic [ST_W-1:0] st;
        logic cmp;
        an = longint'($signed(x.a_num));
        bn = longint'($signed(x.b_num));
        ad = longint'({33'd0, x.a_den});
        bd = longint'({33'd0, x.b_den});
        rn = 0;
        rd = 0;
        cmp = 1'b0;
        st = ST_OK;
        if (x.command <= CMD_LT && (ad == 0 || bd == 0)) begin
            st = ST_ZERODEN;
        end else if ((x.command == CMD_INC || x.command == CMD_DEC) && ad == 0) begin
            st = ST_ZERODEN;
        end else if (x.command == CMD_ADD || x.command == CMD_SUB) begin
            g = longint'(gcd64(ad, bd));
            l = (ad / g) * bd;
            n = (x.command == CMD_ADD) ? an * (l / ad) + bn * (l / bd)
                                       : an * (l / ad) - bn * (l / bd);
            st = reduce_fraction(n, l, rn, rd);
        end else if (x.command == CMD_MUL || x.command == CMD_DIV) begin
            if (x.command == CMD_MUL) begin
                n = an * bn;
                d = ad * bd;
            end else begin
                n = an * bd;
                d = ad * bn;
            end
            if (x.command == CMD_DIV && bn == 0) begin
                st = ST_DIVZERO;
            end else if (!fits_word(n) || !fits_word(d)) begin
                st = ST_OVERFLOW;
            end else begin
                st = reduce_fraction(n, d, rn, rd);
            end
        end else if (x.command >= CMD_EQ && x.command <= CMD_LT) begin
            n = an * bd;
            d = bn * ad;
            case (x.command)
                CMD_EQ: cmp = (n == d);
                CMD_GT: cmp = (n > d);
                default: cmp = (n < d);
            endcase
        end else if (x.command == CMD_INC || x.command == CMD_DEC) begin
            st = reduce_fraction(x.command == CMD_INC ? an + ad : an - ad, ad, rn, rd);
        end
        if (st != ST_OK) begin
            rn = 0;
            rd = 0;
        end
        r.res_num = rn[NUM_W-1:0];
        r.res_den = rd[DEN_W-1:0];
        r.compare_true = cmp;
        r.status = st;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_checked <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                expected_results.push_back(predict_rational(i_in.data));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result num=%0d den=%0d cmp=%0b st=%0d", $time,
                             $signed(i_out.data.res_num), i_out.data.res_den,
                             i_out.data.compare_true, i_out.data.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.data !== want) begin
                        $display("%0t: mismatch expected num=%0d den=%0d cmp=%0b st=%0d",
                                 $time, $signed(want.res_num), want.res_den,
                                 want.compare_true, want.status,
                                 ", actual num=%0d den=%0d cmp=%0b st=%0d",
                                 $signed(i_out.data.res_num), i_out.data.res_den,
                                 i_out.data.compare_true, i_out.data.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
                o_checked <= o_checked + 1;
            end
        end
    end
endmodule

[dv/tb_rational_arithmetic_unit.sv]
// Testbench top that drives the rational arithmetic unit and reports the verdict.
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    localparam int N_RANDOM = 1200;
    localparam int CYCLE_LIMIT = 50000000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   cycles = 0;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   sent;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arithmetic_unit #(.WORD_BITS(32)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    rau_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    function automatic logic [NUM_W-1:0] random_num();
        case ($urandom_range(5))
            0: return NUM_W'($signed($urandom_range(100)) - 50);
            1: return {$urandom_range(1) ? 1'b1 : 1'b0, {(NUM_W-1){$urandom_range(1) == 1}}};
            2: return NUM_W'($signed($urandom_range(65535)) - 32768);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [DEN_W-1:0] random_den();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return DEN_W'($urandom_range(60, 1));
            4: return DEN_W'($urandom_range(65535, 1));
            default: return DEN_W'($urandom());
        endcase
    endfunction

    task automatic send_item(t_in x);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= x;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_fraction(t_cmd c, int an, int unsigned ad, int bn, int unsigned bd);
        t_in x;
        x.command = c;
        x.a_num = an;
        x.a_den = ad[DEN_W-1:0];
        x.b_num = bn;
        x.b_den = bd[DEN_W-1:0];
        send_item(x);
    endtask

    initial begin
        t_in x;
        int wait_cycles;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        i_rst_n = 1'b0;
        sender_idle_pct = 29;
        receiver_idle_pct = 52;
        sent = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_fraction(CMD_ADD, 1, 2, 1, 3);
        send_fraction(CMD_SUB, 1, 2, 3, 4);
        send_fraction(CMD_MUL, -2, 3, 3, 4);
        send_fraction(CMD_DIV, 1, 2, -3, 4);
        send_fraction(CMD_DIV, 5, 7, 0, 9);
        send_fraction(CMD_DIV, 5, 7, 0, 0);
        send_fraction(CMD_ADD, 1, 0, 1, 3);
        send_fraction(CMD_EQ, 1, 2, 2, 4);
        send_fraction(CMD_GT, 32'h7fffffff, 1, 32'h80000000, 1);
        send_fraction(CMD_LT, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_fraction(CMD_INC, 32'h7fffffff, 1, 0, 0);
        send_fraction(CMD_DEC, 32'h80000000, 1, 5, 0);
        send_fraction(CMD_INC, 3, 0, 1, 1);
        send_fraction(CMD_MUL, 65536, 1, 65536, 1);
        send_fraction(CMD_MUL, 65536, 65536, 65536, 65536);
        send_fraction(CMD_DIV, 32'h80000000, 1, -1, 1);
        send_fraction(CMD_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7ffffffe);
        send_fraction(CMD_SUB, 32'h80000000, 1, 32'h7fffffff, 1);
        send_fraction(CMD_ADD, 2, 4, -3, 6);
        send_fraction(CMD_MUL, 0, 5, 7, 3);
        x = '0;
        x.command = 4'd15;
        x.a_num = 9;
        x.a_den = 2;
        send_item(x);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                sender_idle_pct = 52;
                receiver_idle_pct = 29;
            end else if (i == 2 * N_RANDOM / 3) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            x.command = ($urandom_range(19) == 0) ? CMD_W'($urandom_range(15, 9))
                                                  : CMD_W'($urandom_range(8));
            x.a_num = random_num();
            x.a_den = random_den();
            x.b_num = ($urandom_range(15) == 0) ? '0 : random_num();
            x.b_den = random_den();
            send_item(x);
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 600) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        $display("sent %0d transactions covering all commands, error codes",
                 sent, " and three idle patterns");
        $display("checked %0d results with %0d failures", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
